@@ src/ymr_pkg.sv @@
// Package: codes, types and defaults for the YModem packet receiver.
package ymr_pkg;

  localparam int SMALL_PAYLOAD_DEF  = 128;
  localparam int LARGE_PAYLOAD_DEF  = 1024;
  localparam int FRAME_OVERHEAD_DEF = 5;

  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 11;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] CH_SOH   = 8'h01;
  localparam logic [BYTE_W-1:0] CH_STX   = 8'h02;
  localparam logic [BYTE_W-1:0] CH_EOT   = 8'h04;
  localparam logic [BYTE_W-1:0] CH_CA    = 8'h18;
  localparam logic [BYTE_W-1:0] INV_MASK = 8'hff;

  localparam logic [BYTE_W-1:0] ABORT_UPPER_RST = 8'd65;
  localparam logic [BYTE_W-1:0] ABORT_LOWER_RST = 8'd97;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ABORT_UPPER = 2'd0,
    CFG_ABORT_LOWER = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_CA    = 2'd1,
    PH_FRAME = 2'd2
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_BUSY   = 3'd0,
    ST_GOOD   = 3'd1,
    ST_EOT    = 3'd2,
    ST_CANCEL = 3'd3,
    ST_ABORT  = 3'd4,
    ST_ERROR  = 3'd5
  } status_e;

  typedef struct packed {
    status_e           status;
    logic              byte_valid;
    logic [BYTE_W-1:0] frame_byte;
    logic [IDX_W-1:0]  frame_index;
    logic [IDX_W-1:0]  packet_length;
    logic [BYTE_W-1:0] block_number;
  } result_t;

endpackage

@@ src/ymodem_packet_receiver_top.sv @@
// Top level: YModem packet deframer with one result register.
// Latency: a result is presented in the cycle after its request is accepted.
// Throughput: one request per cycle; the next request is taken while the
// result register drains, stalled only when that register is full and held.
// Reset clears the deframer to idle, empties the result register and loads
// the abort characters with 'A' and 'a'.
module ymodem_packet_receiver_top
  import ymr_pkg::*;
#(
  parameter int SMALL_PAYLOAD  = SMALL_PAYLOAD_DEF,
  parameter int LARGE_PAYLOAD  = LARGE_PAYLOAD_DEF,
  parameter int FRAME_OVERHEAD = FRAME_OVERHEAD_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic                 byte_valid_o,
  output logic [BYTE_W-1:0]    frame_byte_o,
  output logic [IDX_W-1:0]     frame_index_o,
  output logic [IDX_W-1:0]     packet_length_o,
  output logic [BYTE_W-1:0]    block_number_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i
);

  localparam int MAX_PAYLOAD = (SMALL_PAYLOAD > LARGE_PAYLOAD) ? SMALL_PAYLOAD : LARGE_PAYLOAD;
  localparam int CNT_W = $clog2(MAX_PAYLOAD + FRAME_OVERHEAD + 1);
  localparam logic [31:0] SMALL_W = SMALL_PAYLOAD;
  localparam logic [31:0] LARGE_W = LARGE_PAYLOAD;
  localparam logic [31:0] SMALL_TOT_W = SMALL_PAYLOAD + FRAME_OVERHEAD;
  localparam logic [31:0] LARGE_TOT_W = LARGE_PAYLOAD + FRAME_OVERHEAD;
  localparam logic [CNT_W-1:0] SMALL_TOTAL = SMALL_TOT_W[CNT_W-1:0];
  localparam logic [CNT_W-1:0] LARGE_TOTAL = LARGE_TOT_W[CNT_W-1:0];
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  logic [BYTE_W-1:0] abort_upper_q, abort_lower_q;
  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              large_q, large_d;
  logic [BYTE_W-1:0] seq_q, seq_d;
  logic              seq_ok_q, seq_ok_d;
  logic              out_valid_q;
  result_t           res_q, res_d;

  logic              accept;
  logic              timeout;
  logic [CNT_W-1:0]  cnt_inc;
  logic              frame_done;
  logic [CNT_W+IDX_W-1:0] idx_ext;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign timeout     = req_type_i;
  assign cnt_inc     = cnt_q + CNT_ONE;
  assign frame_done  = cnt_inc >= (large_q ? LARGE_TOTAL : SMALL_TOTAL);
  assign idx_ext     = {{IDX_W{1'b0}}, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abort_upper_q <= ABORT_UPPER_RST;
      abort_lower_q <= ABORT_LOWER_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ABORT_UPPER: abort_upper_q <= cfg_data_i;
        CFG_ABORT_LOWER: abort_lower_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    large_d  = large_q;
    seq_d    = seq_q;
    seq_ok_d = seq_ok_q;
    unique case (phase_q)
      PH_FRAME: begin
        if (timeout) begin
          phase_d = PH_IDLE;
          cnt_d   = '0;
        end else begin
          if (cnt_q == CNT_ONE) begin
            seq_d = rx_byte_i;
          end else if (cnt_q == CNT_TWO) begin
            seq_ok_d = seq_q == (rx_byte_i ^ INV_MASK);
          end
          if (frame_done) begin
            phase_d = PH_IDLE;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      PH_CA: phase_d = PH_IDLE;
      default: begin
        phase_d = PH_IDLE;
        if (!timeout) begin
          if (rx_byte_i == CH_SOH || rx_byte_i == CH_STX) begin
            phase_d  = PH_FRAME;
            large_d  = rx_byte_i == CH_STX;
            cnt_d    = CNT_ONE;
            seq_d    = '0;
            seq_ok_d = 1'b0;
          end else if (rx_byte_i == CH_CA) begin
            phase_d = PH_CA;
          end
        end
      end
    endcase
  end

  // result
  always_comb begin
    res_d = '{status: ST_ERROR, byte_valid: 1'b0, frame_byte: '0,
              frame_index: '0, packet_length: '0, block_number: '0};
    unique case (phase_q)
      PH_FRAME: begin
        if (!timeout) begin
          res_d.byte_valid  = 1'b1;
          res_d.frame_byte  = rx_byte_i;
          res_d.frame_index = idx_ext[IDX_W-1:0];
          if (!frame_done) begin
            res_d.status = ST_BUSY;
          end else if (seq_ok_q) begin
            res_d.status        = ST_GOOD;
            res_d.packet_length = large_q ? LARGE_W[IDX_W-1:0] : SMALL_W[IDX_W-1:0];
            res_d.block_number  = seq_q;
          end
        end
      end
      PH_CA: begin
        if (!timeout && rx_byte_i == CH_CA) begin
          res_d.status = ST_CANCEL;
        end
      end
      default: begin
        if (!timeout) begin
          priority if (rx_byte_i == CH_SOH || rx_byte_i == CH_STX) begin
            res_d.status     = ST_BUSY;
            res_d.byte_valid = 1'b1;
            res_d.frame_byte = rx_byte_i;
          end else if (rx_byte_i == CH_EOT) begin
            res_d.status = ST_EOT;
          end else if (rx_byte_i == CH_CA) begin
            res_d.status = ST_BUSY;
          end else if (rx_byte_i == abort_upper_q || rx_byte_i == abort_lower_q) begin
            res_d.status = ST_ABORT;
          end else begin
            res_d.status = ST_ERROR;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      large_q     <= 1'b0;
      seq_q       <= '0;
      seq_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        large_q  <= large_d;
        seq_q    <= seq_d;
        seq_ok_q <= seq_ok_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign byte_valid_o    = res_q.byte_valid;
  assign frame_byte_o    = res_q.frame_byte;
  assign frame_index_o   = res_q.frame_index;
  assign packet_length_o = res_q.packet_length;
  assign block_number_o  = res_q.block_number;

endmodule
